### rtl/core/pfcb_pkg.sv
// Package: shared constants, types and helpers for the page framebuffer blitter.
package pfcb_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int DISPLAY_PAGES = 4;
    localparam int COLUMN_BITS   = 32;
    localparam int DISPLAY_ROWS  = DISPLAY_PAGES * 8;
    localparam int STORE_BYTES   = DISPLAY_WIDTH * DISPLAY_PAGES;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int X_W           = $clog2(DISPLAY_WIDTH + 1);
    localparam int PG_W          = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
    localparam int CB_W          = $clog2(COLUMN_BITS);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DRAW_MODE   = 3'd4;

    // Command codes
    localparam logic [1:0] CMD_FILL = 2'd0;
    localparam logic [1:0] CMD_DRAW = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Pixel modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_INVERT = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PAINT,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_RDATA
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  col_x;
        logic [6:0]  col_y;
        logic [31:0] column_bits;
        logic [5:0]  glyph_height;
        logic [1:0]  fill_mode;
        logic [8:0]  read_addr;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       fully_clipped;
    } t_out;

    typedef struct packed {
        logic [7:0] clip_left;
        logic [5:0] clip_top;
        logic [7:0] clip_width;
        logic [5:0] clip_height;
        logic [1:0] draw_mode;
    } t_cfg;

    // One classified command as handed from front to back
    typedef struct packed {
        t_op                     op;
        logic [1:0]              mode;
        logic [X_W-1:0]          x_lo;
        logic [X_W-1:0]          x_hi;
        logic [DISPLAY_ROWS-1:0] rows;
        logic [ADDR_W-1:0]       addr;
        logic                    clipped;
    } t_job;

    // Apply a pixel mode to the masked bits of a byte
    function automatic logic [7:0] apply_mode(logic [7:0] d, logic [7:0] m, logic [1:0] mode);
        logic [7:0] r;
        unique case (mode)
            MODE_CLEAR:  r = d & ~m;
            MODE_SET:    r = d | m;
            default:     r = d ^ m;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/pfcb_queue.sv
// Two-entry job queue between the front and the back.
module pfcb_queue
    import pfcb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);

endmodule

### rtl/core/pfcb_front.sv
// Front end: accept commands, clip them and turn them into jobs.
module pfcb_front
    import pfcb_pkg::*;
(
    input  logic i_take,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output logic o_push,
    output t_job o_job
);

    logic signed [10:0] x0, x1, y0, y1, cx, cy, lo, hi, wl, hl, w, h, gh;
    logic               win_ok, x_in, touched;
    logic [DISPLAY_ROWS-1:0] draw_rows, fill_rows;

    // Work out the effective clip window
    always_comb begin
        win_ok = ({1'b0, i_cfg.clip_left} <= 9'(DISPLAY_WIDTH))
              && ({1'b0, i_cfg.clip_top} <= 7'(DISPLAY_ROWS));
        x0 = 11'(i_cfg.clip_left);
        y0 = 11'(i_cfg.clip_top);
        wl = 11'(DISPLAY_WIDTH) - x0;
        hl = 11'(DISPLAY_ROWS) - y0;
        w  = (11'(i_cfg.clip_width) > wl) ? wl : 11'(i_cfg.clip_width);
        h  = (11'(i_cfg.clip_height) > hl) ? hl : 11'(i_cfg.clip_height);
        x1 = x0 + w;
        y1 = y0 + h;
        win_ok = win_ok && (w != 11'sd0) && (h != 11'sd0);
    end

    // Clip the column and map its pattern onto display rows
    always_comb begin
        logic signed [10:0] k;
        cx = 11'($signed(i_item.col_x));
        cy = 11'($signed(i_item.col_y));
        gh = (11'(i_item.glyph_height) > 11'(COLUMN_BITS)) ? 11'(COLUMN_BITS)
                                                          : 11'(i_item.glyph_height);
        lo = (cy > y0) ? cy : y0;
        hi = ((cy + gh) < y1) ? (cy + gh) : y1;
        x_in = (cx >= x0) && (cx < x1);
        touched = win_ok && x_in && (lo < hi);
        for (int y = 0; y < DISPLAY_ROWS; y++) begin
            k = 11'(y) - cy;
            draw_rows[y] = (11'(y) >= lo) && (11'(y) < hi)
                         && i_item.column_bits[k[CB_W-1:0]];
            fill_rows[y] = (11'(y) >= y0) && (11'(y) < y1);
        end
    end

    // Build the job for the back end
    always_comb begin
        o_job         = '0;
        o_job.op      = OP_NONE;
        o_job.clipped = 1'b1;
        unique case (i_item.cmd)
            CMD_FILL: begin
                if (win_ok) begin
                    o_job.op      = OP_PAINT;
                    o_job.clipped = 1'b0;
                end
                o_job.mode = (i_item.fill_mode == MODE_SPARE) ? MODE_CLEAR : i_item.fill_mode;
                o_job.x_lo = X_W'(x0);
                o_job.x_hi = X_W'(x1);
                o_job.rows = fill_rows;
            end
            CMD_DRAW: begin
                if (touched) begin
                    o_job.op      = OP_PAINT;
                    o_job.clipped = 1'b0;
                end
                o_job.mode = (i_cfg.draw_mode == MODE_SPARE) ? MODE_INVERT : i_cfg.draw_mode;
                o_job.x_lo = X_W'(cx);
                o_job.x_hi = X_W'(cx + 11'sd1);
                o_job.rows = draw_rows;
            end
            CMD_READ: begin
                if ({1'b0, i_item.read_addr} < 10'(STORE_BYTES)) begin
                    o_job.op      = OP_READ;
                    o_job.clipped = 1'b0;
                end
                o_job.addr = ADDR_W'(i_item.read_addr);
            end
            default: begin
                o_job.op = OP_NONE;
            end
        endcase
    end

    assign o_push = i_take;

endmodule

### rtl/core/pfcb_back.sv
// Back end: clear the store after reset, then run jobs byte by byte.
module pfcb_back
    import pfcb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_clearing,
    output logic o_strobe,
    output t_out o_result
);

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rdata;
    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [PG_W-1:0]   r_page, n_page;
    logic [X_W-1:0]    r_x, n_x;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_strobe, n_strobe;
    t_out              r_result, n_result;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr, cur_addr;
    logic [7:0]        mem_wdata, row_mask;

    assign cur_addr = ADDR_W'(int'(r_page) * DISPLAY_WIDTH) + ADDR_W'(r_x);
    assign row_mask = r_job.rows[8*r_page +: 8];

    // Frame store with a registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_page   <= n_page;
        r_x      <= n_x;
        r_result <= n_result;
    end

    // Sequence clearing, read-modify-write and reads
    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_page    = r_page;
        n_x       = r_x;
        n_clr     = r_clr;
        n_strobe  = 1'b0;
        n_result  = r_result;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = cur_addr;
        mem_raddr = cur_addr;
        mem_wdata = apply_mode(r_rdata, row_mask, r_job.mode);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'h00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_page = '0;
                    n_x    = i_job.x_lo;
                    unique case (i_job.op)
                        OP_PAINT: n_state = ST_RD;
                        OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = i_job.addr;
                            n_state   = ST_RDATA;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_result = '{read_data: 8'h00, fully_clipped: i_job.clipped};
                        end
                    endcase
                end
            end
            ST_RD: begin
                mem_re  = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                mem_we  = 1'b1;
                n_state = ST_RD;
                if (r_x + 1'b1 == r_job.x_hi) begin
                    n_x    = r_job.x_lo;
                    n_page = r_page + 1'b1;
                    if (r_page == PG_W'(DISPLAY_PAGES - 1)) begin
                        n_state  = ST_IDLE;
                        n_strobe = 1'b1;
                        n_result = '{read_data: 8'h00, fully_clipped: 1'b0};
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            ST_RDATA: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                n_result = '{read_data: r_rdata, fully_clipped: 1'b0};
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_strobe   = r_strobe;
    assign o_result   = r_result;

    // Result follows a return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == ST_IDLE) else $error("result outside idle");

    // Writes only while clearing or in the write step
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_WR))
        else $error("store written in wrong state");

    // No result and no job pop during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !o_pop && !r_strobe)
        else $error("activity during clearing pass");

endmodule

### rtl/core/page_framebuffer_clipped_blitter.sv
// Top level: configuration registers, command handshake, front, queue and back.
//
//  channel   direction  handshake                    payload
//  command   in         start & !busy                i_item (t_in)
//  result    out        o_strobe, one cycle          o_result (t_out)
//  config    in         psel & penable & pwrite      pwdata, paddr
//
// A read command does one store read; clipped and unused commands touch no store.
// A column draw does one read-modify-write (a read step, then a write step) per
// page; a fill does one per column of the clip window on every page.
// After reset a clearing pass over all STORE_BYTES (512) bytes holds busy high.
// busy stays high from acceptance until the result strobe; results cannot stall.
module page_framebuffer_clipped_blitter
    import pfcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    output logic        o_strobe,
    output t_out        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    logic       r_busy;
    logic       take, push, pop, empty, clearing;
    logic [2:0] reg_idx;
    t_job       f_job, q_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign busy    = r_busy | clearing;
    assign take    = start & ~busy;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{clip_left: 8'd0, clip_top: 6'd0, clip_width: 8'd128,
                       clip_height: 6'd32, draw_mode: MODE_SET};
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_CLIP_LEFT:   r_cfg.clip_left   <= pwdata[7:0];
                REG_CLIP_TOP:    r_cfg.clip_top    <= pwdata[5:0];
                REG_CLIP_WIDTH:  r_cfg.clip_width  <= pwdata[7:0];
                REG_CLIP_HEIGHT: r_cfg.clip_height <= pwdata[5:0];
                REG_DRAW_MODE:   r_cfg.draw_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Return register contents
    always_comb begin
        unique case (reg_idx)
            REG_CLIP_LEFT:   prdata = 32'(r_cfg.clip_left);
            REG_CLIP_TOP:    prdata = 32'(r_cfg.clip_top);
            REG_CLIP_WIDTH:  prdata = 32'(r_cfg.clip_width);
            REG_CLIP_HEIGHT: prdata = 32'(r_cfg.clip_height);
            REG_DRAW_MODE:   prdata = 32'(r_cfg.draw_mode);
            default:         prdata = 32'h0;
        endcase
    end

    // Hold busy from acceptance to result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (o_strobe) begin
            r_busy <= 1'b0;
        end
    end

    pfcb_front u_front (
        .i_take (take),
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_push (push),
        .o_job  (f_job)
    );

    pfcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (empty)
    );

    pfcb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
